@@ hdl/cartridge_bank_latch_mapper_top_macros.svh @@
// Assertion macros used by the checker file of the bank latch mapper.
`ifndef CARTRIDGE_BANK_LATCH_MAPPER_TOP_MACROS_SVH
`define CARTRIDGE_BANK_LATCH_MAPPER_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CBLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define CBLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/cblm_pkg.sv @@
// Package with the word types and codes of the cartridge bank latch mapper.
package cblm_pkg;

  // Bus event codes carried in the command field.
  localparam logic [1:0] CMD_WR_LOW  = 2'd0;
  localparam logic [1:0] CMD_WR_HIGH = 2'd1;
  localparam logic [1:0] CMD_RD_LOW  = 2'd2;
  localparam logic [1:0] CMD_SOFT_RST = 2'd3;

  // Mapper variant codes.
  localparam logic [2:0] VAR_LOW_LATCH   = 3'd0;
  localparam logic [2:0] VAR_MASK_LATCH  = 3'd1;
  localparam logic [2:0] VAR_HIGH_LATCH  = 3'd2;
  localparam logic [2:0] VAR_HIGH_LATCH2 = 3'd3;
  localparam logic [2:0] VAR_MULTI_LATCH = 3'd4;
  localparam logic [2:0] VAR_RESET       = VAR_MULTI_LATCH;

  // Command register codes of the multi-latch variant.
  localparam logic [2:0] SEL_CHR_BIT3 = 3'd2;
  localparam logic [2:0] SEL_CHR_BIT2 = 3'd4;
  localparam logic [2:0] SEL_PRG      = 3'd5;
  localparam logic [2:0] SEL_CHR_LOW  = 3'd6;
  localparam logic [2:0] SEL_MIRROR   = 3'd7;

  // Address decode masks.
  localparam logic [15:0] MULTI_CMD_MASK  = 16'h4101;
  localparam logic [15:0] MULTI_CMD_MATCH = 16'h4100;
  localparam logic [15:0] MULTI_RD_MASK   = 16'h4100;
  localparam logic [15:0] MASK_WR_MASK    = 16'h0103;
  localparam logic [15:0] MASK_WR_MATCH   = 16'h0102;
  localparam logic [15:0] LOW_WR_BIT      = 16'h0100;

  // Configuration register index.
  localparam logic REG_VARIANT = 1'b0;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_word_t;

  typedef struct packed {
    logic       handled;
    logic [7:0] read_data;
    logic [2:0] prg_bank;
    logic [3:0] chr_bank;
    logic [1:0] mirror_mode;
    logic       mirror_valid;
  } out_word_t;

endpackage

@@ hdl/cblm_core.sv @@
// Latch state of the mapper, its update for one bus word, and the bank decode.
module cblm_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  cblm_pkg::in_word_t item_i,
  input  logic [2:0]         variant_i,
  output cblm_pkg::out_word_t result_o
);
  import cblm_pkg::*;

  logic [2:0] select_q, select_d;
  logic [7:0] main_q, main_d;
  logic [1:0] chr_low_q, chr_low_d;
  logic [1:0] mirror_q, mirror_d;
  logic       chr_bit3_q, chr_bit3_d;
  logic       chr_bit2_q, chr_bit2_d;
  logic       switch_q, switch_d;
  logic       handled;
  logic [7:0] rdata;
  logic       mask_hit;

  assign mask_hit = (item_i.address & MASK_WR_MASK) == MASK_WR_MATCH;

  // Next latch values, claim flag and read data for the word in the input register.
  always_comb begin
    select_d   = select_q;
    main_d     = main_q;
    chr_low_d  = chr_low_q;
    mirror_d   = mirror_q;
    chr_bit3_d = chr_bit3_q;
    chr_bit2_d = chr_bit2_q;
    switch_d   = switch_q;
    handled    = 1'b0;
    rdata      = 8'h00;
    if (variant_i <= VAR_MULTI_LATCH) begin
      case (item_i.command)
        CMD_SOFT_RST: begin
          handled = 1'b1;
          main_d  = 8'h00;
          if (variant_i == VAR_MULTI_LATCH) begin
            chr_low_d  = 2'b00;
            mirror_d   = 2'b00;
            chr_bit3_d = 1'b0;
            chr_bit2_d = 1'b0;
            switch_d   = ~switch_q;
          end
        end
        CMD_WR_LOW: begin
          if (variant_i == VAR_LOW_LATCH) begin
            handled = 1'b1;
            if ((item_i.address & LOW_WR_BIT) != 16'h0000) main_d = item_i.write_data;
          end else if (variant_i == VAR_MASK_LATCH) begin
            handled = 1'b1;
            if (mask_hit) main_d = item_i.write_data;
          end else if (variant_i == VAR_MULTI_LATCH) begin
            handled = 1'b1;
            if ((item_i.address & MULTI_CMD_MASK) == MULTI_CMD_MATCH) begin
              select_d = item_i.write_data[2:0];
            end else begin
              unique case (select_q)
                SEL_CHR_BIT3: begin
                  main_d     = {7'd0, item_i.write_data[0]};
                  chr_bit3_d = item_i.write_data[0];
                end
                SEL_CHR_BIT2: chr_bit2_d = item_i.write_data[0];
                SEL_PRG:      main_d = {5'd0, item_i.write_data[2:0]};
                SEL_CHR_LOW:  chr_low_d = item_i.write_data[1:0];
                SEL_MIRROR:   mirror_d = item_i.write_data[2:1];
                default: ;
              endcase
            end
          end
        end
        CMD_WR_HIGH: begin
          if (variant_i == VAR_MASK_LATCH) begin
            handled = 1'b1;
            if (mask_hit) main_d = item_i.write_data;
          end else if (variant_i == VAR_HIGH_LATCH || variant_i == VAR_HIGH_LATCH2) begin
            handled = 1'b1;
            main_d  = item_i.write_data;
          end
        end
        default: begin
          // Low-region read answers only in the multi-latch variant.
          if (variant_i == VAR_MULTI_LATCH &&
              (item_i.address & MULTI_RD_MASK) == MULTI_RD_MASK) begin
            handled = 1'b1;
            rdata   = {2'b00, 3'b111, ~select_q[2:1], ~select_q[0] ^ switch_q};
          end
        end
      endcase
    end
  end

  // Bank decode from the updated latches.
  always_comb begin
    result_o              = '0;
    result_o.handled      = handled;
    result_o.read_data    = rdata;
    unique case (variant_i)
      VAR_LOW_LATCH, VAR_HIGH_LATCH: begin
        result_o.prg_bank = {2'b00, main_d[3]};
        result_o.chr_bank = {1'b0, main_d[2:0]};
      end
      VAR_MASK_LATCH: begin
        result_o.prg_bank = {1'b0, main_d[7], main_d[2]};
        result_o.chr_bank = main_d[6:3];
      end
      VAR_HIGH_LATCH2: begin
        result_o.chr_bank = {3'b000, main_d[7]};
      end
      VAR_MULTI_LATCH: begin
        result_o.prg_bank     = main_d[2:0];
        result_o.chr_bank     = {chr_bit3_d, chr_bit2_d, chr_low_d};
        result_o.mirror_mode  = mirror_d;
        result_o.mirror_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // Latch registers advance when the word moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_q   <= 3'd0;
      main_q     <= 8'h00;
      chr_low_q  <= 2'b00;
      mirror_q   <= 2'b00;
      chr_bit3_q <= 1'b0;
      chr_bit2_q <= 1'b0;
      switch_q   <= 1'b1;
    end else if (fire_i) begin
      select_q   <= select_d;
      main_q     <= main_d;
      chr_low_q  <= chr_low_d;
      mirror_q   <= mirror_d;
      chr_bit3_q <= chr_bit3_d;
      chr_bit2_q <= chr_bit2_d;
      switch_q   <= switch_d;
    end
  end

endmodule

@@ hdl/cblm_regs.sv @@
// Configuration register file with its APB-style access port.
module cblm_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [2:0]  variant_o
);
  import cblm_pkg::*;

  logic [2:0] variant_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_VARIANT);

  // Read back the variant register wherever paddr[2] is low; other addresses read as zero.
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_VARIANT) prdata = {29'd0, variant_q};
  end

  // Variant register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VAR_RESET;
    end else if (wr_en) begin
      variant_q <= pwdata[2:0];
    end
  end

  assign variant_o = variant_q;

endmodule

@@ hdl/cartridge_bank_latch_mapper_top.sv @@
// Top level of the cartridge bank latch mapper: input register, core, result register.
// An accepted word moves on to the output register once that register is free or read.
// One word per cycle without output stalls; the latch update sits between the registers.
// The input register keeps taking words while a result waits, until both are full.
// Reset (rst_ni low, asynchronous) empties both registers, clears the latches,
// sets the switch bit and selects the multi-latch variant.
module cartridge_bank_latch_mapper_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cblm_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cblm_pkg::out_word_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cblm_pkg::*;

  in_word_t  in_word_q;
  logic      in_valid_q;
  out_word_t out_word_q;
  logic      out_valid_q;
  out_word_t result;
  logic [2:0] variant;
  logic      advance;

  // The input word moves on when the result register is free or being read.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  cblm_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .variant_o(variant)
  );

  cblm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_word_q),
    .variant_i(variant),
    .result_o (result)
  );

  // Valid flags of the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_word_q <= in_data_i;
    if (advance) out_word_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

@@ hdl/cblm_checker.sv @@
// Port-level checker of the cartridge bank latch mapper and its bind.
`include "cartridge_bank_latch_mapper_top_macros.svh"

module cblm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cblm_pkg::out_word_t out_data_o,
  input logic                pready
);
  import cblm_pkg::*;

  // A stalled result word stays offered.
  `CBLM_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result word dropped while stalled")

  // The input side only blocks behind a waiting result.
  `CBLM_ASSERT_ALWAYS(a_in_block, !in_ready_o |-> out_valid_o, "input blocked with empty output")

  // Unclaimed events never return read data.
  `CBLM_ASSERT(a_rdata_zero, out_valid_o && !out_data_o.handled |-> out_data_o.read_data == 8'h00, "read data on unclaimed event")

  // Mirroring reads as zero when the variant does not drive it.
  `CBLM_ASSERT(a_mirror_off, out_valid_o && !out_data_o.mirror_valid |-> out_data_o.mirror_mode == 2'b00, "mirror mode without mirror valid")

  // The register port never inserts wait states.
  `CBLM_ASSERT_ALWAYS(a_pready, pready, "register port not ready")

endmodule

bind cartridge_bank_latch_mapper_top cblm_checker u_cblm_checker (.*);
